// ===== rtl/core/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg: shared types and constants of the directory entry filter/sort
// Entry record kept in the sort memory, filter result, state encoding and
// the character constants used by the name filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

	// default capacity of the entry store
	localparam int MAX_ENTRIES_DEF = 64;

	// characters
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_B   = 8'h42;
	localparam logic [7:0] CH_I   = 8'h49;
	localparam logic [7:0] CH_N   = 8'h4E;

	// ".BIN" as it sits in four little-endian name bytes
	localparam logic [31:0] BIN_EXT = {CH_N, CH_I, CH_B, CH_DOT};

	// name length limits
	localparam logic [3:0] NAME_MAX_LEN = 4'd12;
	localparam logic [3:0] DIR_MAX_LEN  = 4'd8;
	localparam logic [3:0] EXT_LEN      = 4'd4;
	localparam logic [3:0] PARENT_LEN   = 4'd2;
	localparam logic [63:0] PARENT_NAME = {48'h0, CH_DOT, CH_DOT};

	// sort groups, lowest first
	localparam logic [1:0] RANK_PARENT = 2'd0;
	localparam logic [1:0] RANK_DIR    = 2'd1;
	localparam logic [1:0] RANK_FILE   = 2'd2;

	// one stored entry
	typedef struct packed {
		logic        dir;
		logic [3:0]  len;
		logic [63:0] name;
	} entry_t;

	// filter decision for the incoming entry
	typedef struct packed {
		logic   keep;
		entry_t entry;
	} filt_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_SCAN,
		S_START,
		S_KEY,
		S_CMP,
		S_PLACE,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMPTY
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/dfs_filter.sv =====
// ----------------------------------------------------------------------------
// dfs_filter: directory entry filter
// Decides whether an incoming entry is stored and builds the stored record:
// file extension stripped, name zero filled past the stored length.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_filter import dfs_pkg::*; (
	input  logic        is_dir,
	input  logic        is_hidden,
	input  logic [3:0]  name_len,
	input  logic [63:0] name_head,
	input  logic [31:0] name_tail,
	output filt_t       filt
);

	logic [95:0] name_all;
	logic [95:0] name_sh;
	logic [3:0]  ext_base;
	logic        len_ok;
	logic        is_dot;
	logic        is_parent;
	logic        has_dot;
	logic        ext_ok;
	logic        keep_entry;
	logic [3:0]  store_len;
	logic [63:0] name_mask;

	// name checks
	always_comb begin
		name_all  = {name_tail, name_head};
		ext_base  = name_len - EXT_LEN;
		// wraps to a large shift for short names, which yields zero
		name_sh   = name_all >> {ext_base, 3'b000};
		len_ok    = (name_len <= NAME_MAX_LEN);
		is_dot    = is_dir && (name_len == 4'd1) && (name_head[7:0] == CH_DOT);
		is_parent = is_dir && (name_len == PARENT_LEN) &&
			(name_head[15:0] == {CH_DOT, CH_DOT});
		has_dot   = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if ((4'(i) < name_len) && (name_head[8*i +: 8] == CH_DOT))
				has_dot = 1'b1;
		end
		ext_ok    = (name_len > EXT_LEN) && (name_sh[31:0] == BIN_EXT);
	end

	// keep decision, order matters
	always_comb begin
		priority if (!len_ok)
			keep_entry = 1'b0;
		else if (is_dot)
			keep_entry = 1'b0;
		else if (is_parent)
			keep_entry = 1'b1;
		else if (is_hidden)
			keep_entry = 1'b0;
		else if (is_dir)
			keep_entry = (name_len <= DIR_MAX_LEN) && !has_dot;
		else
			keep_entry = ext_ok;
	end

	// stored record
	always_comb begin
		store_len = is_dir ? name_len : ext_base;
		for (int i = 0; i < 8; i++)
			name_mask[8*i +: 8] = (4'(i) < store_len) ? 8'hFF : 8'h00;
		filt.keep       = keep_entry;
		filt.entry.dir  = is_dir;
		filt.entry.len  = store_len;
		filt.entry.name = name_head & name_mask;
	end

endmodule

`default_nettype wire

// ===== rtl/core/directory_entry_filter_sort.sv =====
// ----------------------------------------------------------------------------
// directory_entry_filter_sort: filters directory entries and emits them sorted
// Usage:
//   Input channel (in_valid/in_ready) takes one directory entry per cycle
//   while scanning. Each kept entry is written into a single entry memory.
//   The transfer with last set, or the MAX_ENTRIES-th transfer, ends the scan;
//   in_ready then drops until the last sorted result is loaded for output.
//   Sort: stable insertion sort over the memory (read one entry, shift
//   larger ones up one place). One compare per cycle.
//   Output channel (out_valid/out_ready) then gives one result per cycle,
//   while the receiver takes them, from a registered output stage fed by the registered memory read.
//   A stalled receiver holds the output register and the emit sequence.
//   An empty list gives a single result with entry_valid low.
//   After the last result is loaded into the output register, scanning
//   resumes while that result still waits to be taken.
//   Reset clears the sequencer and counters; the memory is not cleared
//   since only entries below the kept count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module directory_entry_filter_sort import dfs_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        is_dir,
	input  logic        is_hidden,
	input  logic [3:0]  name_len,
	input  logic [63:0] name_head,
	input  logic [31:0] name_tail,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        entry_valid,
	output logic        out_is_dir,
	output logic [3:0]  out_len,
	output logic [63:0] out_name,
	output logic        out_last
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(MAX_ENTRIES - 1);

	// rank of a stored entry
	function automatic logic [1:0] rank_of(entry_t e);
		logic [1:0] r;
		if (e.dir && (e.len == PARENT_LEN) && (e.name == PARENT_NAME))
			r = RANK_PARENT;
		else if (e.dir)
			r = RANK_DIR;
		else
			r = RANK_FILE;
		return r;
	endfunction

	// a strictly before b: group, then bytes of common prefix, then length
	function automatic logic goes_before(entry_t a, entry_t b);
		logic [1:0]  ra;
		logic [1:0]  rb;
		logic [3:0]  n;
		logic [63:0] ka;
		logic [63:0] kb;
		logic        res;
		ra = rank_of(a);
		rb = rank_of(b);
		n  = (a.len < b.len) ? a.len : b.len;
		for (int i = 0; i < 8; i++) begin
			ka[63-8*i -: 8] = (4'(i) < n) ? a.name[8*i +: 8] : 8'h00;
			kb[63-8*i -: 8] = (4'(i) < n) ? b.name[8*i +: 8] : 8'h00;
		end
		priority if (ra != rb)
			res = (ra < rb);
		else if (ka != kb)
			res = (ka < kb);
		else
			res = (a.len < b.len);
		return res;
	endfunction

	filt_t            filt;
	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] kept_q;
	logic [CNT_W-1:0] scanned_q;
	logic [CNT_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	entry_t           key_q;
	entry_t           rdata_q;
	entry_t           mem [MAX_ENTRIES];

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	logic             in_xfer;
	logic             final_item;
	logic             key_first;
	logic [CNT_W-1:0] i_next;
	logic [CNT_W-1:0] i_m1;
	logic [CNT_W-1:0] k_next;
	logic             sort_done;
	logic             emit_last;
	logic             slot_free;
	logic             out_load;
	logic             out_load_empty;
	logic             out_valid_q;

	dfs_filter u_filter (
		.is_dir    (is_dir),
		.is_hidden (is_hidden),
		.name_len  (name_len),
		.name_head (name_head),
		.name_tail (name_tail),
		.filt      (filt)
	);

	// shared status terms
	assign in_ready   = (state_q == S_SCAN);
	assign in_xfer    = in_valid && in_ready;
	assign final_item = last || (scanned_q == SCAN_END);
	assign key_first  = goes_before(key_q, rdata_q);
	assign i_next     = i_q + CNT_W'(1);
	assign i_m1       = i_q - CNT_W'(1);
	assign k_next     = CNT_W'(k_q) + CNT_W'(1);
	assign sort_done  = (i_next == kept_q);
	assign emit_last  = (k_next == kept_q);
	assign slot_free  = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SCAN: begin
				if (in_xfer && final_item)
					state_d = S_START;
			end
			S_START: begin
				if (kept_q >= CNT_W'(2))
					state_d = S_KEY;
				else if (kept_q == '0)
					state_d = S_EMPTY;
				else
					state_d = S_EMIT_RD;
			end
			S_KEY: state_d = S_CMP;
			S_CMP: begin
				if (key_first)
					state_d = (j_q == '0) ? S_PLACE : S_CMP;
				else
					state_d = sort_done ? S_EMIT_RD : S_KEY;
			end
			S_PLACE:   state_d = sort_done ? S_EMIT_RD : S_KEY;
			S_EMIT_RD: state_d = S_EMIT_LD;
			S_EMIT_LD: begin
				if (slot_free && emit_last)
					state_d = S_SCAN;
			end
			S_EMPTY: begin
				if (slot_free)
					state_d = S_SCAN;
			end
			default: state_d = S_SCAN;
		endcase
	end

	// memory and output stage control
	// a write in the compare loop lands above the entry read while shifting and
	// below it otherwise, so read and write never hit the same entry in one cycle
	always_comb begin
		rd_en          = 1'b0;
		rd_addr        = '0;
		wr_en          = 1'b0;
		wr_addr        = '0;
		wr_data        = filt.entry;
		out_load       = 1'b0;
		out_load_empty = 1'b0;
		unique case (state_q)
			S_SCAN: begin
				wr_en   = in_xfer && filt.keep;
				wr_addr = kept_q[IDX_W-1:0];
			end
			S_START: begin
				rd_en   = (kept_q >= CNT_W'(2));
				rd_addr = IDX_W'(1);
			end
			S_KEY: begin
				rd_en   = 1'b1;
				rd_addr = i_m1[IDX_W-1:0];
			end
			S_CMP: begin
				wr_en   = 1'b1;
				wr_addr = j_q + IDX_W'(1);
				wr_data = key_first ? rdata_q : key_q;
				if (key_first) begin
					rd_en   = (j_q != '0);
					rd_addr = j_q - IDX_W'(1);
				end else begin
					rd_en   = !sort_done;
					rd_addr = i_next[IDX_W-1:0];
				end
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = key_q;
				rd_en   = !sort_done;
				rd_addr = i_next[IDX_W-1:0];
			end
			S_EMIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = k_q;
			end
			S_EMIT_LD: begin
				out_load = slot_free;
				rd_en    = slot_free && !emit_last;
				rd_addr  = k_next[IDX_W-1:0];
			end
			S_EMPTY: out_load_empty = slot_free;
			default: ;
		endcase
	end

	// entry memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SCAN;
			kept_q      <= '0;
			scanned_q   <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// scan counters
			if (state_q == S_SCAN && in_xfer) begin
				scanned_q <= final_item ? '0 : scanned_q + CNT_W'(1);
				if (filt.keep)
					kept_q <= kept_q + CNT_W'(1);
			end
			if ((state_q == S_EMIT_LD && out_load && emit_last) || out_load_empty)
				kept_q <= '0;
			// sort indexes
			if (state_q == S_START)
				i_q <= CNT_W'(1);
			else if ((state_q == S_CMP && !key_first) || state_q == S_PLACE)
				i_q <= i_next;
			if (state_q == S_KEY)
				j_q <= i_m1[IDX_W-1:0];
			else if (state_q == S_CMP && key_first && j_q != '0)
				j_q <= j_q - IDX_W'(1);
			// emit index
			if (state_q == S_SCAN)
				k_q <= '0;
			else if (out_load && !emit_last)
				k_q <= k_next[IDX_W-1:0];
			// output stage valid
			if (out_load || out_load_empty)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// key register and output payload
	always_ff @(posedge clk) begin
		if (state_q == S_KEY)
			key_q <= rdata_q;
		if (out_load) begin
			entry_valid <= 1'b1;
			out_is_dir  <= rdata_q.dir;
			out_len     <= rdata_q.len;
			out_name    <= rdata_q.name;
			out_last    <= emit_last;
		end else if (out_load_empty) begin
			entry_valid <= 1'b0;
			out_is_dir  <= 1'b0;
			out_len     <= '0;
			out_name    <= '0;
			out_last    <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= CNT_W'(MAX_ENTRIES))
		else $error("kept count above capacity");

	a_stop_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && final_item) |=> !in_ready)
		else $error("input still taken after end of scan");

	a_j_below_i: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (CNT_W'(j_q) < i_q))
		else $error("compare index not below insert index");

	a_sort_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KEY) |-> (i_q < kept_q))
		else $error("insert index past kept count");

endmodule

`default_nettype wire

// ===== test/directory_entry_filter_sort_tb.sv =====
// ----------------------------------------------------------------------------
// directory_entry_filter_sort_tb: self-checking bench for the entry sorter
// Feeds directory scans through the input channel and predicts the sorted
// listing with a behavioral filter and stable insertion sort kept in the
// bench. Every result transfer is checked field by field against the oldest
// prediction. Directed scans cover the filter corner cases, then random scans
// (mostly well-formed names, some noise) run with bursty input, a stalling
// receiver, one long receiver hold-off and one scan that hits the entry limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module directory_entry_filter_sort_tb import dfs_pkg::*;;

	localparam int SCAN_LIMIT    = MAX_ENTRIES_DEF;
	localparam int RANDOM_ITEMS  = 64;
	localparam int LONG_HOLD     = 400;
	localparam int DRAIN_CYCLES  = 200;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [3:0] DOT_LEN = 4'd1;

	// one input transfer plus a flag that holds it back until the listing drained
	typedef struct packed {
		logic        is_dir;
		logic        is_hidden;
		logic [3:0]  name_len;
		logic [95:0] name_bytes;
		logic        last;
		logic        wait_drain;
	} scan_item_t;

	typedef struct packed {
		logic        entry_valid;
		logic        is_dir;
		logic [3:0]  len;
		logic [63:0] name;
		logic        last;
	} listing_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        is_dir = 1'b0;
	logic        is_hidden = 1'b0;
	logic [3:0]  name_len = '0;
	logic [63:0] name_head = '0;
	logic [31:0] name_tail = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        entry_valid;
	logic        out_is_dir;
	logic [3:0]  out_len;
	logic [63:0] out_name;
	logic        out_last;

	scan_item_t  scan_items[$];
	listing_t    expected_listing[$];
	entry_t      kept_entries[$];
	int          scanned_in_scan = 0;
	int          mismatch_count = 0;
	int          results_seen = 0;

	directory_entry_filter_sort dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.is_dir      (is_dir),
		.is_hidden   (is_hidden),
		.name_len    (name_len),
		.name_head   (name_head),
		.name_tail   (name_tail),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.entry_valid (entry_valid),
		.out_is_dir  (out_is_dir),
		.out_len     (out_len),
		.out_name    (out_name),
		.out_last    (out_last)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// zero the name bytes at and past len
	function automatic logic [63:0] trim_name(logic [63:0] v, logic [3:0] len);
		for (int i = 0; i < 8; i++)
			if (i >= len)
				v[8*i +: 8] = '0;
		return v;
	endfunction

	// filter one entry; files lose their .BIN extension
	function automatic filt_t screen_entry(scan_item_t it);
		filt_t      f;
		logic [7:0] b0;
		logic [7:0] b1;
		f  = '0;
		b0 = it.name_bytes[7:0];
		b1 = it.name_bytes[15:8];
		if (it.name_len > NAME_MAX_LEN)
			return f;
		if (it.is_dir && it.name_len == DOT_LEN && b0 == CH_DOT)
			return f;
		// parent entry survives even when hidden
		if (it.is_dir && it.name_len == PARENT_LEN && b0 == CH_DOT && b1 == CH_DOT) begin
			f.keep = 1'b1;
			f.entry = '{dir: 1'b1, len: PARENT_LEN, name: PARENT_NAME};
			return f;
		end
		if (it.is_hidden)
			return f;
		if (it.is_dir) begin
			if (it.name_len > DIR_MAX_LEN)
				return f;
			for (int i = 0; i < it.name_len; i++)
				if (it.name_bytes[8*i +: 8] == CH_DOT)
					return f;
			f.keep = 1'b1;
			f.entry = '{dir: 1'b1, len: it.name_len,
				name: trim_name(it.name_bytes[63:0], it.name_len)};
		end else if (it.name_len > EXT_LEN &&
				it.name_bytes[8*(it.name_len - EXT_LEN) +: 32] == BIN_EXT) begin
			f.keep = 1'b1;
			f.entry = '{dir: 1'b0, len: it.name_len - EXT_LEN,
				name: trim_name(it.name_bytes[63:0], it.name_len - EXT_LEN)};
		end
		return f;
	endfunction

	function automatic logic [1:0] group_of(entry_t e);
		if (e.dir && e.len == PARENT_LEN && e.name == PARENT_NAME)
			return RANK_PARENT;
		return e.dir ? RANK_DIR : RANK_FILE;
	endfunction

	// strict ordering: group, then unsigned bytes, then shorter prefix first
	function automatic logic sorts_before(entry_t a, entry_t b);
		logic [1:0] ga;
		logic [1:0] gb;
		int         n;
		ga = group_of(a);
		gb = group_of(b);
		if (ga != gb)
			return ga < gb;
		n = (a.len < b.len) ? a.len : b.len;
		for (int i = 0; i < n; i++)
			if (a.name[8*i +: 8] != b.name[8*i +: 8])
				return a.name[8*i +: 8] < b.name[8*i +: 8];
		return a.len < b.len;
	endfunction

	// accepted entry: store it, and on the end of a scan predict the listing
	task automatic record_entry(scan_item_t it);
		filt_t    f;
		entry_t   tmp;
		listing_t r;
		int       j;
		f = screen_entry(it);
		if (f.keep && kept_entries.size() < SCAN_LIMIT)
			kept_entries.push_back(f.entry);
		scanned_in_scan++;
		if (!it.last && scanned_in_scan < SCAN_LIMIT)
			return;
		for (int i = 1; i < kept_entries.size(); i++) begin
			j = i;
			while (j > 0 && sorts_before(kept_entries[j], kept_entries[j-1])) begin
				tmp = kept_entries[j];
				kept_entries[j] = kept_entries[j-1];
				kept_entries[j-1] = tmp;
				j--;
			end
		end
		if (kept_entries.size() == 0) begin
			r = '{entry_valid: 1'b0, is_dir: 1'b0, len: '0, name: '0, last: 1'b1};
			expected_listing.push_back(r);
		end
		foreach (kept_entries[i]) begin
			r = '{entry_valid: 1'b1, is_dir: kept_entries[i].dir, len: kept_entries[i].len,
				name: kept_entries[i].name, last: (i == kept_entries.size() - 1)};
			expected_listing.push_back(r);
		end
		kept_entries.delete();
		scanned_in_scan = 0;
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// named entry with junk past the name
	function automatic scan_item_t named_entry(logic d, logic h, string s, logic l);
		scan_item_t it;
		it.is_dir     = d;
		it.is_hidden  = h;
		it.name_len   = 4'(s.len());
		it.name_bytes = {$urandom, $urandom, $urandom};
		for (int i = 0; i < s.len(); i++)
			it.name_bytes[8*i +: 8] = s[i];
		it.last       = l;
		it.wait_drain = 1'b0;
		return it;
	endfunction

	// small alphabet so names share prefixes, with an odd full-range byte
	function automatic logic [7:0] name_char();
		case ($urandom_range(0, 3))
			0: return "A";
			1: return "B";
			2: return "C";
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// random entry; clean ones are always kept
	function automatic scan_item_t random_entry(bit clean);
		scan_item_t it;
		int         kind;
		int         pos;
		kind = clean ? $urandom_range(0, 5) : $urandom_range(0, 9);
		it.name_bytes = {$urandom, $urandom, $urandom};
		it.is_hidden  = clean ? 1'b0 : ($urandom_range(0, 7) == 0);
		it.last       = 1'b0;
		it.wait_drain = 1'b0;
		case (kind)
			0, 1, 2: begin
				it.is_dir   = 1'b1;
				it.name_len = 4'($urandom_range(0, 8));
				for (int i = 0; i < it.name_len; i++) begin
					it.name_bytes[8*i +: 8] = name_char();
					if (clean && it.name_bytes[8*i +: 8] == CH_DOT)
						it.name_bytes[8*i +: 8] = "A";
				end
			end
			3, 4, 5: begin
				it.is_dir   = 1'b0;
				it.name_len = 4'($urandom_range(5, 12));
				for (int i = 0; i < it.name_len - EXT_LEN; i++)
					it.name_bytes[8*i +: 8] = name_char();
				it.name_bytes[8*(it.name_len - EXT_LEN) +: 32] = BIN_EXT;
				// broken extension now and then
				if (!clean && $urandom_range(0, 5) == 0) begin
					pos = $urandom_range(it.name_len - EXT_LEN, it.name_len - 1);
					it.name_bytes[8*pos + 5] = ~it.name_bytes[8*pos + 5];
				end
			end
			6: begin
				it.is_dir   = 1'b1;
				it.name_len = PARENT_LEN;
				it.name_bytes[15:0] = {CH_DOT, CH_DOT};
			end
			7: begin
				it.is_dir   = 1'b1;
				it.name_len = DOT_LEN;
				it.name_bytes[7:0] = CH_DOT;
			end
			8: begin
				it.is_dir   = 1'($urandom_range(0, 1));
				it.is_hidden = 1'($urandom_range(0, 1));
				it.name_len = 4'($urandom_range(0, 15));
			end
			default: begin
				// names of any length with dots sprinkled in
				it.is_dir   = 1'($urandom_range(0, 1));
				it.name_len = 4'($urandom_range(0, 15));
				for (int i = 0; i < 12; i++)
					it.name_bytes[8*i +: 8] = ($urandom_range(0, 2) == 0) ? CH_DOT : name_char();
			end
		endcase
		return it;
	endfunction

	// ------------------------------------------------------------------
	// input driver: bursts with random gaps, predicts on each transfer
	// ------------------------------------------------------------------
	scan_item_t cur_item;
	int         burst_left;
	int         gap_left;
	logic       offer;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_valid && in_ready)
				record_entry(cur_item);
			if (!(in_valid && !in_ready)) begin
				offer = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (scan_items.size() != 0 &&
						!(scan_items[0].wait_drain && expected_listing.size() != 0)) begin
					cur_item = scan_items.pop_front();
					offer = 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
				in_valid <= offer;
				if (offer) begin
					is_dir    <= cur_item.is_dir;
					is_hidden <= cur_item.is_hidden;
					name_len  <= cur_item.name_len;
					name_head <= cur_item.name_bytes[63:0];
					name_tail <= cur_item.name_bytes[95:64];
					last      <= cur_item.last;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver stall pattern, with one long hold-off
	// ------------------------------------------------------------------
	int   ready_mode;
	int   mode_left;
	int   long_hold_left;
	bit   long_hold_done;
	logic ready_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready      <= 1'b0;
			ready_mode     = 0;
			mode_left      = 0;
			long_hold_left = 0;
			long_hold_done = 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(20, 150);
			end else begin
				mode_left--;
			end
			if (!long_hold_done && out_valid && results_seen >= 20) begin
				long_hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				ready_next = 1'b0;
			end else begin
				case (ready_mode)
					0: ready_next = 1'b1;
					1: ready_next = 1'($urandom_range(0, 1));
					default: ready_next = ($urandom_range(0, 7) != 0);
				endcase
			end
			out_ready <= ready_next;
		end
	end

	// ------------------------------------------------------------------
	// result monitor
	// ------------------------------------------------------------------
	task automatic flag_field(string field, logic [63:0] want, logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch in %s at result %0d: expected %h, got %h",
				field, results_seen, want, got);
	endtask

	listing_t want_entry;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_listing.size() == 0) begin
				flag_field("result with nothing pending", '0, out_name);
			end else begin
				want_entry = expected_listing.pop_front();
				if (entry_valid !== want_entry.entry_valid)
					flag_field("entry_valid", 64'(want_entry.entry_valid), 64'(entry_valid));
				if (out_is_dir !== want_entry.is_dir)
					flag_field("out_is_dir", 64'(want_entry.is_dir), 64'(out_is_dir));
				if (out_len !== want_entry.len)
					flag_field("out_len", 64'(want_entry.len), 64'(out_len));
				if (out_name !== want_entry.name)
					flag_field("out_name", want_entry.name, out_name);
				if (out_last !== want_entry.last)
					flag_field("out_last", 64'(want_entry.last), 64'(out_last));
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence: directed scans, random scans, drain, verdict
	// ------------------------------------------------------------------
	initial begin
		scan_item_t it;
		int         scan_len;
		int         random_count;
		bit         limit_done;

		// scan 1: filter corner cases, ends on a kept file
		scan_items.push_back(named_entry(1'b1, 1'b0, ".", 1'b0));
		scan_items.push_back(named_entry(1'b1, 1'b1, "..", 1'b0));
		scan_items.push_back(named_entry(1'b1, 1'b0, "GAMES", 1'b0));
		scan_items.push_back(named_entry(1'b0, 1'b0, "ZED.BIN", 1'b0));
		scan_items.push_back(named_entry(1'b0, 1'b0, "ABCDEFGH.BIN", 1'b0));
		scan_items.push_back(named_entry(1'b0, 1'b0, "...BIN", 1'b0));
		scan_items.push_back(named_entry(1'b0, 1'b1, "HID.BIN", 1'b0));
		scan_items.push_back(named_entry(1'b0, 1'b0, "low.bin", 1'b0));
		scan_items.push_back(named_entry(1'b0, 1'b0, ".BIN", 1'b0));
		scan_items.push_back(named_entry(1'b1, 1'b0, "A.B", 1'b0));
		scan_items.push_back(named_entry(1'b1, 1'b0, "...", 1'b0));
		scan_items.push_back(named_entry(1'b1, 1'b0, "LONGNAME9", 1'b0));
		scan_items.push_back(named_entry(1'b1, 1'b0, "", 1'b0));
		scan_items.push_back(named_entry(1'b1, 1'b0, "GAME", 1'b0));
		// oversized lengths are dropped even with a valid-looking name
		it = named_entry(1'b0, 1'b0, "ABCDEFGH.BIN", 1'b0);
		it.name_len = 4'd13;
		scan_items.push_back(it);
		it = named_entry(1'b1, 1'b0, "", 1'b0);
		it.name_len = 4'd15;
		scan_items.push_back(it);
		// bytes at both ends of the unsigned range
		it = named_entry(1'b1, 1'b0, "AB", 1'b0);
		it.name_bytes[15:0] = 16'h80FF;
		scan_items.push_back(it);
		it = named_entry(1'b1, 1'b0, "ABC", 1'b0);
		it.name_bytes[23:0] = 24'h410001;
		scan_items.push_back(it);
		scan_items.push_back(named_entry(1'b0, 1'b0, "Z.BIN", 1'b1));
		// scan 2: nothing kept, empty listing
		scan_items.push_back(named_entry(1'b1, 1'b0, ".", 1'b1));
		// scan 3: starts only once the listing drained
		it = named_entry(1'b1, 1'b0, "..", 1'b0);
		it.wait_drain = 1'b1;
		scan_items.push_back(it);
		scan_items.push_back(named_entry(1'b0, 1'b0, "A.BIN", 1'b1));

		// random scans, with one full-length scan that ends on the limit
		random_count = 0;
		limit_done = 1'b0;
		while (random_count < RANDOM_ITEMS) begin
			if (!limit_done && random_count >= RANDOM_ITEMS / 2) begin
				for (int k = 0; k < SCAN_LIMIT; k++)
					scan_items.push_back(random_entry(1'b1));
				limit_done = 1'b1;
			end
			scan_len = $urandom_range(1, 20);
			for (int k = 0; k < scan_len; k++) begin
				it = random_entry(1'b0);
				it.last = (k == scan_len - 1);
				it.wait_drain = (k == 0) && ($urandom_range(0, 5) == 0);
				scan_items.push_back(it);
				random_count++;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (scan_items.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_listing.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_listing.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
